### design/assert_macros.svh
// shared assertion forms for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GBB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gbb_pkg.sv
`timescale 1ns / 1ps

package gbb_pkg;

  // port field widths
  localparam int CMD_W       = 1;
  localparam int START_COL_W = 8;
  localparam int START_ROW_W = 6;
  localparam int BOX_X_W     = 9;
  localparam int BOX_Y_W     = 7;
  localparam int BOX_W_W     = 9;
  localparam int BOX_H_W     = 7;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int IMG_W_REG_W = 9;
  localparam int IMG_H_REG_W = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_REG_W-1:0] IMAGE_WIDTH_RESET  = 9'd256;
  localparam logic [IMG_H_REG_W-1:0] IMAGE_HEIGHT_RESET = 7'd64;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // query sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_COL_RD,
    S_COL_EV,
    S_LNK_RD,
    S_LNK_EV,
    S_TOP_SET,
    S_TOP_RD,
    S_TOP_EV,
    S_BOT_SET,
    S_BOT_RD,
    S_BOT_EV,
    S_EMIT
  } scan_state_t;

  // which pixel of a link test is being read
  typedef enum logic [1:0] {
    K_SELF,
    K_RIGHT,
    K_UPR,
    K_DNR
  } link_step_t;

endpackage

### design/gbb_ram.sv
`timescale 1ns / 1ps

module gbb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/gbb_scan.sv
`timescale 1ns / 1ps

module gbb_scan #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    query,
  input  logic [gbb_pkg::START_COL_W-1:0]         start_col,
  input  logic [gbb_pkg::START_ROW_W-1:0]         start_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]          eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]         eff_h,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] total,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] rd_addr,
  input  logic                                    rd_data,
  output logic                                    busy,
  output logic                                    done,
  output logic [gbb_pkg::BOX_X_W-1:0]             box_x,
  output logic [gbb_pkg::BOX_Y_W-1:0]             box_y,
  output logic [gbb_pkg::BOX_W_W-1:0]             box_w,
  output logic [gbb_pkg::BOX_H_W-1:0]             box_h
);

  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PW  = WB + HB;
  localparam int SCW = (WB > gbb_pkg::START_COL_W) ? WB : gbb_pkg::START_COL_W;
  localparam int SRW = (HB > gbb_pkg::START_ROW_W) ? HB : gbb_pkg::START_ROW_W;
  localparam int BXW = gbb_pkg::BOX_X_W;
  localparam int BYW = gbb_pkg::BOX_Y_W;
  localparam int BWW = gbb_pkg::BOX_W_W;
  localparam int BHW = gbb_pkg::BOX_H_W;

  gbb_pkg::scan_state_t state, state_next;
  gbb_pkg::link_step_t  k, k_next;

  logic [WB-1:0] xs, xs_next;       // left edge
  logic [WB-1:0] cs, cs_next;       // column under test / right edge
  logic [WB-1:0] cc, cc_next;       // column within a row scan
  logic [WB-1:0] wd, wd_next;       // box width
  logic [HB-1:0] r, r_next;         // row within a column scan
  logic [HB-1:0] y, y_next;         // top row
  logic [HB-1:0] b, b_next;         // bottom row candidate
  logic [HB-1:0] h, h_next;         // box height
  logic [AW-1:0] addr, addr_next;
  logic [AW-1:0] row_base, row_base_next;

  logic [WB-1:0] x_clamp;
  logic [HB-1:0] y_clamp;
  logic [HB-1:0] hm1;
  logic [TW-1:0] w_t;
  logic [WB:0]   cs_p1, cs_p2, w_ext, xs_ext;
  logic [PW-1:0] top_prod;
  logic [TW-1:0] rd_sum;
  logic          lnk_link, lnk_row_done;

  assign x_clamp = (SCW'(start_col) > SCW'(eff_w)) ? eff_w : WB'(start_col);
  assign y_clamp = (SRW'(start_row) > SRW'(eff_h)) ? eff_h : HB'(start_row);
  assign hm1     = eff_h - HB'(1);
  assign w_t     = TW'(eff_w);
  assign cs_p1   = (WB+1)'(cs) + (WB+1)'(1);
  assign cs_p2   = (WB+1)'(cs) + (WB+1)'(2);
  assign w_ext   = (WB+1)'(eff_w);
  assign xs_ext  = (WB+1)'(xs);
  assign top_prod = PW'(y) * PW'(eff_w);

  // read address: column walk, link neighbors, or row walk
  always_comb begin
    rd_sum = TW'(addr);
    unique case (state)
      gbb_pkg::S_LNK_RD: begin
        unique case (k)
          gbb_pkg::K_SELF:  rd_sum = TW'(addr);
          gbb_pkg::K_RIGHT: rd_sum = TW'(addr) + TW'(1);
          gbb_pkg::K_UPR:   rd_sum = TW'(addr) + TW'(1) - w_t;
          gbb_pkg::K_DNR:   rd_sum = TW'(addr) + TW'(1) + w_t;
          default:          rd_sum = TW'(addr);
        endcase
      end
      gbb_pkg::S_TOP_RD, gbb_pkg::S_BOT_RD: rd_sum = TW'(row_base) + TW'(cc);
      default: rd_sum = TW'(addr);
    endcase
  end

  assign rd_addr = AW'(rd_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    xs       <= xs_next;
    cs       <= cs_next;
    cc       <= cc_next;
    wd       <= wd_next;
    r        <= r_next;
    y        <= y_next;
    b        <= b_next;
    h        <= h_next;
    addr     <= addr_next;
    row_base <= row_base_next;
  end

  always_comb begin
    state_next    = state;
    k_next        = k;
    xs_next       = xs;
    cs_next       = cs;
    cc_next       = cc;
    wd_next       = wd;
    r_next        = r;
    y_next        = y;
    b_next        = b;
    h_next        = h;
    addr_next     = addr;
    row_base_next = row_base;
    lnk_link      = 1'b0;
    lnk_row_done  = 1'b0;

    unique case (state)
      gbb_pkg::S_IDLE: begin
        if (query) begin
          y_next = y_clamp;
          if (x_clamp == eff_w) begin
            xs_next    = eff_w;
            wd_next    = '0;
            state_next = gbb_pkg::S_TOP_SET;
          end else begin
            cs_next    = x_clamp;
            r_next     = '0;
            addr_next  = AW'(x_clamp);
            state_next = gbb_pkg::S_COL_RD;
          end
        end
      end

      gbb_pkg::S_COL_RD: state_next = gbb_pkg::S_COL_EV;

      gbb_pkg::S_COL_EV: begin
        if (rd_data) begin
          xs_next = cs;
          if (cs_p1 >= w_ext) begin
            wd_next    = WB'(1);
            state_next = gbb_pkg::S_TOP_SET;
          end else begin
            r_next     = '0;
            addr_next  = AW'(cs);
            k_next     = gbb_pkg::K_SELF;
            state_next = gbb_pkg::S_LNK_RD;
          end
        end else if (r == hm1) begin
          if (cs_p1 >= w_ext) begin
            // no ink at or right of the start column
            xs_next    = eff_w;
            wd_next    = '0;
            state_next = gbb_pkg::S_TOP_SET;
          end else begin
            cs_next    = WB'(cs_p1);
            r_next     = '0;
            addr_next  = AW'(cs_p1);
            state_next = gbb_pkg::S_COL_RD;
          end
        end else begin
          r_next     = r + HB'(1);
          addr_next  = AW'(TW'(addr) + w_t);
          state_next = gbb_pkg::S_COL_RD;
        end
      end

      gbb_pkg::S_LNK_RD: state_next = gbb_pkg::S_LNK_EV;

      gbb_pkg::S_LNK_EV: begin
        state_next = gbb_pkg::S_LNK_RD;
        unique case (k)
          gbb_pkg::K_SELF: begin
            if (rd_data) k_next = gbb_pkg::K_RIGHT;
            else lnk_row_done = 1'b1;
          end
          gbb_pkg::K_RIGHT: begin
            if (rd_data) lnk_link = 1'b1;
            else if (r != '0) k_next = gbb_pkg::K_UPR;
            else if (r != hm1) k_next = gbb_pkg::K_DNR;
            else lnk_row_done = 1'b1;
          end
          gbb_pkg::K_UPR: begin
            if (rd_data) lnk_link = 1'b1;
            else if (r != hm1) k_next = gbb_pkg::K_DNR;
            else lnk_row_done = 1'b1;
          end
          gbb_pkg::K_DNR: begin
            if (rd_data) lnk_link = 1'b1;
            else lnk_row_done = 1'b1;
          end
          default: lnk_row_done = 1'b1;
        endcase

        if (lnk_link) begin
          cs_next = WB'(cs_p1);
          if (cs_p2 >= w_ext) begin
            // glyph runs into the last column
            wd_next    = WB'(cs_p2 - xs_ext);
            state_next = gbb_pkg::S_TOP_SET;
          end else begin
            r_next    = '0;
            addr_next = AW'(cs_p1);
            k_next    = gbb_pkg::K_SELF;
          end
        end else if (lnk_row_done) begin
          if (r == hm1) begin
            wd_next    = WB'(cs_p1 - xs_ext);
            state_next = gbb_pkg::S_TOP_SET;
          end else begin
            r_next    = r + HB'(1);
            addr_next = AW'(TW'(addr) + w_t);
            k_next    = gbb_pkg::K_SELF;
          end
        end
      end

      gbb_pkg::S_TOP_SET: begin
        if (wd == '0 || y == eff_h) begin
          y_next     = eff_h;
          h_next     = '0;
          state_next = gbb_pkg::S_EMIT;
        end else begin
          row_base_next = AW'(top_prod);
          cc_next       = xs;
          state_next    = gbb_pkg::S_TOP_RD;
        end
      end

      gbb_pkg::S_TOP_RD: state_next = gbb_pkg::S_TOP_EV;

      gbb_pkg::S_TOP_EV: begin
        if (rd_data) begin
          state_next = gbb_pkg::S_BOT_SET;
        end else if (cc == cs) begin
          if (y == hm1) begin
            y_next     = eff_h;
            h_next     = '0;
            state_next = gbb_pkg::S_EMIT;
          end else begin
            y_next        = y + HB'(1);
            row_base_next = AW'(TW'(row_base) + w_t);
            cc_next       = xs;
            state_next    = gbb_pkg::S_TOP_RD;
          end
        end else begin
          cc_next    = cc + WB'(1);
          state_next = gbb_pkg::S_TOP_RD;
        end
      end

      gbb_pkg::S_BOT_SET: begin
        b_next        = hm1;
        row_base_next = AW'(total - w_t);
        cc_next       = xs;
        if (hm1 == y) begin
          h_next     = HB'(1);
          state_next = gbb_pkg::S_EMIT;
        end else begin
          state_next = gbb_pkg::S_BOT_RD;
        end
      end

      gbb_pkg::S_BOT_RD: state_next = gbb_pkg::S_BOT_EV;

      gbb_pkg::S_BOT_EV: begin
        if (rd_data) begin
          h_next     = b - y + HB'(1);
          state_next = gbb_pkg::S_EMIT;
        end else if (cc == cs) begin
          if (b - HB'(1) == y) begin
            h_next     = HB'(1);
            state_next = gbb_pkg::S_EMIT;
          end else begin
            b_next        = b - HB'(1);
            row_base_next = AW'(TW'(row_base) - w_t);
            cc_next       = xs;
            state_next    = gbb_pkg::S_BOT_RD;
          end
        end else begin
          cc_next    = cc + WB'(1);
          state_next = gbb_pkg::S_BOT_RD;
        end
      end

      gbb_pkg::S_EMIT: state_next = gbb_pkg::S_IDLE;

      default: state_next = gbb_pkg::S_IDLE;
    endcase
  end

  assign busy  = (state != gbb_pkg::S_IDLE);
  assign done  = (state == gbb_pkg::S_EMIT);
  assign box_x = BXW'(xs);
  assign box_y = BYW'(y);
  assign box_w = BWW'(wd);
  assign box_h = BHW'(h);

endmodule

### design/glyph_bounding_box_finder.sv
`timescale 1ns / 1ps

// Glyph bounding box finder. A binary image (1 = ink) is loaded one pixel per
// transfer in row-major order: start with cmd = 0 carries the pixel on ink,
// loads are taken every cycle while busy is low and keep busy low. A transfer
// with cmd = 1 asks for the box of the glyph found from start_col / start_row;
// busy then stays high while a small sequencer walks the pixel memory through
// its one read port, each pixel read being an address followed by registered
// data. Skipping empty columns reads up to H pixels per column, each link test
// between neighbouring columns reads up to four pixels per row, and row
// trimming reads the box columns of each row looked at. The result is shown
// on box_x/box_y/box_w/box_h for exactly one cycle with done high and there is
// no way to hold it off, so the receiver must take it then. A box of
// (W, H, 0, 0) means no ink was found. Queries only read the image, so a query
// issued before the whole image is loaded sees pixels that may be stale or
// never written. The user must write image_width / image_height only while
// idle; the block itself does not enforce it. A value of 0 acts as 1 and a
// value above the maximum acts as the maximum.
// The pixel memory is not cleared after reset.

module glyph_bounding_box_finder #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // command transfer
  input  logic                              start,
  output logic                              busy,
  input  logic [gbb_pkg::CMD_W-1:0]         cmd,
  input  logic                              ink,
  input  logic [gbb_pkg::START_COL_W-1:0]   start_col,
  input  logic [gbb_pkg::START_ROW_W-1:0]   start_row,
  // result strobe
  output logic                              done,
  output logic [gbb_pkg::BOX_X_W-1:0]       box_x,
  output logic [gbb_pkg::BOX_Y_W-1:0]       box_y,
  output logic [gbb_pkg::BOX_W_W-1:0]       box_w,
  output logic [gbb_pkg::BOX_H_W-1:0]       box_h,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [gbb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int PW    = WB + HB;
  localparam int IWW   = gbb_pkg::IMG_W_REG_W;
  localparam int IHW   = gbb_pkg::IMG_H_REG_W;

  logic [IWW-1:0] image_width;
  logic [IHW-1:0] image_height;
  logic [WB-1:0]  eff_w;
  logic [HB-1:0]  eff_h;
  logic [PW-1:0]  area;
  logic [TW-1:0]  total;

  logic [AW-1:0]  load_pos, load_pos_next;
  logic [AW-1:0]  load_addr;
  logic [TW-1:0]  load_inc;
  logic           load_take;
  logic           query_take;

  logic [AW-1:0]  rd_addr;
  logic           rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gbb_pkg::IMAGE_WIDTH_RESET;
      image_height <= gbb_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gbb_pkg::REG_IMAGE_WIDTH:  image_width  <= IWW'(cfg_data);
        gbb_pkg::REG_IMAGE_HEIGHT: image_height <= IHW'(cfg_data);
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize clips to the maximum
  always_comb begin
    if (image_width == '0) begin
      eff_w = WB'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(image_width);
    end
  end

  always_comb begin
    if (image_height == '0) begin
      eff_h = HB'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = HB'(MAX_HEIGHT);
    end else begin
      eff_h = HB'(image_height);
    end
  end

  assign area  = PW'(eff_w) * PW'(eff_h);
  assign total = TW'(area);

  assign load_take  = start && !busy && (cmd == gbb_pkg::CMD_LOAD);
  assign query_take = start && !busy && (cmd == gbb_pkg::CMD_QUERY);

  // load pointer wraps after the last pixel, and restarts if the geometry
  // shrank below it mid-load
  assign load_addr = (TW'(load_pos) >= total) ? '0 : load_pos;
  assign load_inc  = TW'(load_addr) + TW'(1);
  assign load_pos_next = (load_inc >= total) ? '0 : AW'(load_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
    end else if (load_take) begin
      load_pos <= load_pos_next;
    end
  end

  gbb_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_pixels (
    .clk     (clk),
    .we      (load_take),
    .wr_addr (load_addr),
    .wr_data (ink),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gbb_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .query     (query_take),
    .start_col (start_col),
    .start_row (start_row),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .total     (total),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .done      (done),
    .box_x     (box_x),
    .box_y     (box_y),
    .box_w     (box_w),
    .box_h     (box_h)
  );

endmodule

### design/gbb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [gbb_pkg::CMD_W-1:0]     cmd,
  input logic                          done,
  input logic [gbb_pkg::BOX_W_W-1:0]   box_w,
  input logic [gbb_pkg::BOX_H_W-1:0]   box_h
);

  `GBB_ASSERT_IMP(a_done_after_query, clk, rst, done, $past(busy), "result without a query")
  `GBB_ASSERT_IMP(a_empty_box, clk, rst, done && (box_w == '0), box_h == '0, "empty box has height")
  `GBB_ASSERT_NXT(a_query_busy, clk, rst, start && !busy && (cmd == gbb_pkg::CMD_QUERY), busy, "query not started")
  `GBB_ASSERT_NXT(a_load_free, clk, rst, start && !busy && (cmd == gbb_pkg::CMD_LOAD), !busy, "load blocked the port")
  `GBB_ASSERT_NXT(a_single_strobe, clk, rst, done, !done, "result shown twice")

endmodule

bind glyph_bounding_box_finder gbb_checker u_gbb_checker (.*);
